FILE: sv/hbe_pkg.sv
// shared types and constants for the histogram binning engine
`default_nettype none

package hbe_pkg;

  // item kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  // configuration register indexes
  localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [1:0] REG_BINS_USED  = 2'd2;
  localparam logic [1:0] REG_INV_WIDTH  = 2'd3;

  // configuration reset values
  localparam logic [31:0] RANGE_LOW_RST  = 32'h0000_0000;
  localparam logic [31:0] RANGE_HIGH_RST = 32'h0001_0000;
  localparam logic [8:0]  BINS_USED_RST  = 9'd256;
  localparam logic [31:0] INV_WIDTH_RST  = 32'h0100_0000;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // input item
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] sample;
    logic [7:0]         bin_select;
  } in_item_t;

  // result item
  typedef struct packed {
    logic        in_range;
    logic [31:0] bin_value;
    logic [31:0] total_samples;
  } out_item_t;

  // configuration as seen by the front
  typedef struct packed {
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [8:0]         bins_in_use;
    logic [31:0]        inverse_bin_width;
  } cfg_t;

  // classified command handed from front to back
  typedef struct packed {
    kind_t op;
    logic  in_range;
    logic  sel_ok;
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/hbe_ram.sv
// generic single write port ram with registered read
`default_nettype none

module hbe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/hbe_queue.sv
// short command fifo between front and back
`default_nettype none

module hbe_queue #(
  parameter int W = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            push,
  input  wire logic [W-1:0]                    din,
  input  wire logic                            pop,
  output logic      [W-1:0]                    dout,
  output logic                                 empty,
  output logic      [hbe_pkg::QUEUE_CNT_W-1:0] count
);

  import hbe_pkg::*;

  logic [W-1:0]           entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;

  assign dout  = entries[rd_ptr];
  assign empty = (count == '0);

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: sv/hbe_front.sv
// front: accepts items, range checks samples and computes the bin index
`default_nettype none

module hbe_front #(
  parameter int BINS = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire hbe_pkg::in_item_t               item,
  output logic                                 busy,
  input  wire hbe_pkg::cfg_t                   cfg,
  input  wire logic                            sweeping,
  input  wire logic [hbe_pkg::QUEUE_CNT_W-1:0] q_count,
  output logic                                 push,
  output hbe_pkg::cmd_t                        cmd,
  output logic      [$clog2(BINS)-1:0]         addr
);

  import hbe_pkg::*;

  localparam int AW = $clog2(BINS);

  logic                 accept;
  logic [QUEUE_CNT_W:0] pending;
  logic                 hit_c;
  logic [31:0]          diff_c;

  // stage a
  logic        a_valid;
  logic [1:0]  a_kind;
  logic        a_in_range;
  logic [31:0] a_diff;
  logic [7:0]  a_sel;

  // stage b
  logic [63:0] prod;
  logic        b_valid;
  logic [1:0]  b_kind;
  logic        b_in_range;
  logic [31:0] b_idx;
  logic [7:0]  b_sel;

  // clamp
  logic [31:0]   n_raw;
  logic [31:0]   n_eff;
  logic [31:0]   last_bin;
  logic [AW-1:0] bin_addr;

  // hold off when queued plus in-flight items could fill the queue
  assign pending = (QUEUE_CNT_W + 1)'(q_count) + (QUEUE_CNT_W + 1)'(a_valid)
                 + (QUEUE_CNT_W + 1)'(b_valid);
  assign busy    = sweeping || (pending >= (QUEUE_CNT_W + 1)'(QUEUE_DEPTH));
  assign accept  = start && !busy;

  // range check and offset from the lower edge
  assign hit_c  = ($signed(cfg.range_low) <= $signed(item.sample))
               && ($signed(item.sample) <= $signed(cfg.range_high));
  assign diff_c = item.sample - cfg.range_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_kind     <= item.kind;
    a_in_range <= hit_c;
    a_diff     <= diff_c;
    a_sel      <= item.bin_select;
  end

  // scale offset by bins per unit, keep the integer part
  assign prod = {32'd0, a_diff} * {32'd0, cfg.inverse_bin_width};

  always_ff @(posedge clk) begin
    b_kind     <= a_kind;
    b_in_range <= a_in_range;
    b_idx      <= prod[63:32];
    b_sel      <= a_sel;
  end

  // effective bin count and clamp into the last bin in use
  assign n_raw    = (cfg.bins_in_use == 9'd0) ? 32'd1 : 32'(cfg.bins_in_use);
  assign n_eff    = (n_raw > 32'(BINS)) ? 32'(BINS) : n_raw;
  assign last_bin = n_eff - 32'd1;
  assign bin_addr = (b_idx >= n_eff) ? AW'(last_bin) : AW'(b_idx);

  // hand the classified command to the queue
  assign push         = b_valid;
  assign cmd.op       = kind_t'(b_kind);
  assign cmd.in_range = b_in_range;
  assign cmd.sel_ok   = (32'(b_sel) < 32'(BINS));
  assign addr         = (b_kind == KIND_READ) ? AW'(b_sel) : bin_addr;

endmodule

`default_nettype wire

FILE: sv/hbe_back.sv
// back: bin memory read-modify-write, total counter, clearing sweep, results
`default_nettype none

module hbe_back #(
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    q_empty,
  input  wire hbe_pkg::cmd_t           head_cmd,
  input  wire logic [$clog2(BINS)-1:0] head_addr,
  output logic                         pop,
  output logic                         sweeping,
  output logic                         done,
  output hbe_pkg::out_item_t           result
);

  import hbe_pkg::*;

  localparam int AW = $clog2(BINS);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ACCESS = 3'b010,
    ST_SWEEP  = 3'b100
  } state_t;

  state_t                 state;
  cmd_t                   cur_cmd;
  logic [AW-1:0]          cur_addr;
  logic [AW-1:0]          sweep_addr;
  logic [COUNT_WIDTH-1:0] total;
  logic [COUNT_WIDTH-1:0] total_next;
  logic [COUNT_WIDTH-1:0] rdata;
  logic                   we;
  logic [AW-1:0]          waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic                   is_sample;

  // saturating increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (v == '1) ? v : v + COUNT_WIDTH'(1);
  endfunction

  // clip a count to the 32 bit result field
  function automatic logic [31:0] clip32(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    clip32 = (e[63:32] != 32'd0) ? 32'hFFFF_FFFF : e[31:0];
  endfunction

  assign sweeping   = (state == ST_SWEEP);
  assign pop        = (state == ST_IDLE) && !q_empty;
  assign is_sample  = (cur_cmd.op == KIND_SAMPLE);
  assign total_next = is_sample ? sat_inc(total) : total;

  // bin memory write: zeros while sweeping, else the incremented bin
  assign we    = sweeping || ((state == ST_ACCESS) && is_sample && cur_cmd.in_range);
  assign waddr = sweeping ? sweep_addr : cur_addr;
  assign wdata = sweeping ? '0 : sat_inc(rdata);

  hbe_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(BINS)
  ) u_bins (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(head_addr),
    .rdata(rdata)
  );

  // sequencer, total counter and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      total      <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (head_cmd.op == KIND_CLEAR) begin
              state      <= ST_SWEEP;
              sweep_addr <= '0;
              total      <= '0;
              done       <= 1'b1;
            end else begin
              state <= ST_ACCESS;
            end
          end
        end
        ST_ACCESS: begin
          total <= total_next;
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_SWEEP: begin
          if (sweep_addr == AW'(BINS - 1)) begin
            state <= ST_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // current command and result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_cmd  <= head_cmd;
      cur_addr <= head_addr;
      if (head_cmd.op == KIND_CLEAR) begin
        result.in_range      <= 1'b0;
        result.bin_value     <= 32'd0;
        result.total_samples <= 32'd0;
      end
    end
    if (state == ST_ACCESS) begin
      result.in_range      <= is_sample && cur_cmd.in_range;
      result.bin_value     <= ((cur_cmd.op == KIND_READ) && cur_cmd.sel_ok) ?
                              clip32(rdata) : 32'd0;
      result.total_samples <= clip32(total_next);
    end
  end

endmodule

`default_nettype wire

FILE: sv/histogram_binning_engine_unit.sv
// top level of the histogram binning engine with its configuration registers
`default_nettype none

// Equal-width bin histogram on signed Q16.16 samples. An item is taken when
// start is high and busy is low; each item gives exactly one result, shown
// for one cycle with done high, which the receiver must take as it comes.
// An item passes the front's registered stages (range check, then the index
// multiply), waits in a four-entry command queue, and goes through the back,
// where the bin memory's registered read and write-back set the pace: the
// back finishes one item before it pops the next, and the front takes new
// items until the queue could fill. A clear item reports at once and then
// zeroes the bin memory one entry per cycle with busy high; the same pass runs after reset.
// Configuration writes are taken at any time and should be made while idle.
module histogram_binning_engine_unit #(
  parameter int BINS        = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire hbe_pkg::in_item_t  item,
  output logic                    busy,
  output logic                    done,
  output hbe_pkg::out_item_t      result,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  import hbe_pkg::*;

  localparam int AW = $clog2(BINS);
  localparam int QW = $bits(cmd_t) + AW;

  cfg_t                   cfg;
  logic [1:0]             reg_idx;
  logic                   cfg_write;
  logic                   sweeping;
  logic [QUEUE_CNT_W-1:0] q_count;
  logic                   q_empty;
  logic                   push;
  logic                   pop;
  cmd_t                   push_cmd;
  logic [AW-1:0]          push_addr;
  logic [QW-1:0]          q_dout;
  cmd_t                   head_cmd;
  logic [AW-1:0]          head_addr;

  // configuration port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_low         <= RANGE_LOW_RST;
      cfg.range_high        <= RANGE_HIGH_RST;
      cfg.bins_in_use       <= BINS_USED_RST;
      cfg.inverse_bin_width <= INV_WIDTH_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_RANGE_LOW:  cfg.range_low         <= pwdata;
        REG_RANGE_HIGH: cfg.range_high        <= pwdata;
        REG_BINS_USED:  cfg.bins_in_use       <= pwdata[8:0];
        REG_INV_WIDTH:  cfg.inverse_bin_width <= pwdata;
        default:        cfg.range_low         <= cfg.range_low;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_RANGE_LOW:  prdata = cfg.range_low;
      REG_RANGE_HIGH: prdata = cfg.range_high;
      REG_BINS_USED:  prdata = 32'(cfg.bins_in_use);
      REG_INV_WIDTH:  prdata = cfg.inverse_bin_width;
      default:        prdata = 32'd0;
    endcase
  end

  hbe_front #(
    .BINS(BINS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .cfg     (cfg),
    .sweeping(sweeping),
    .q_count (q_count),
    .push    (push),
    .cmd     (push_cmd),
    .addr    (push_addr)
  );

  hbe_queue #(
    .W(QW)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({push_cmd, push_addr}),
    .pop  (pop),
    .dout (q_dout),
    .empty(q_empty),
    .count(q_count)
  );

  // split the queue head into command and address
  assign head_cmd  = cmd_t'(q_dout[QW-1:AW]);
  assign head_addr = q_dout[AW-1:0];

  hbe_back #(
    .BINS       (BINS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .head_cmd (head_cmd),
    .head_addr(head_addr),
    .pop      (pop),
    .sweeping (sweeping),
    .done     (done),
    .result   (result)
  );

endmodule

`default_nettype wire

FILE: dv/histogram_binning_engine_unit_test.sv
// self-checking testbench for the histogram binning engine top level
`timescale 1ns / 1ps

module histogram_binning_engine_unit_test;
  import hbe_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int NUM_BINS = 256;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 148;

  typedef struct {
    in_item_t cmd;
    bit       hold;
  } queued_cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  in_item_t    item = '0;
  logic        busy;
  logic        done;
  out_item_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  queued_cmd_t commands_waiting[$];
  out_item_t   reports_due[$];

  // mirror of the bin store, the total and the register settings
  logic [31:0]        bin_tally [NUM_BINS];
  logic [31:0]        sample_count;
  logic signed [31:0] lo_edge;
  logic signed [31:0] hi_edge;
  logic [8:0]         bins_used;
  logic [31:0]        bins_per_unit;

  bit taken = 1'b0;
  bit no_gaps = 1'b0;
  int gap_left = 0;
  int errors = 0;
  int stall_cycles = 0;

  histogram_binning_engine_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // zero and oversized bin counts are folded into the usable range
  function automatic int active_bins();
    if (bins_used == 9'd0) return 1;
    if (bins_used > NUM_BINS) return NUM_BINS;
    return bins_used;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // apply one item to the mirror and return the report it should produce
  function automatic out_item_t tally_command(in_item_t c);
    out_item_t   r;
    logic [31:0] offset;
    logic [63:0] prod;
    logic [31:0] idx;
    r = '0;
    case (c.kind)
      KIND_SAMPLE: begin
        sample_count = bump(sample_count);
        if ($signed(c.sample) >= lo_edge && $signed(c.sample) <= hi_edge) begin
          offset = c.sample - lo_edge;
          prod = {32'd0, offset} * {32'd0, bins_per_unit};
          idx = prod[63:32];
          // top edge and overshoot land in the last bin
          if (idx >= active_bins()) idx = active_bins() - 1;
          bin_tally[idx] = bump(bin_tally[idx]);
          r.in_range = 1'b1;
        end
      end
      KIND_READ: r.bin_value = bin_tally[c.bin_select];
      KIND_CLEAR: begin
        foreach (bin_tally[i]) bin_tally[i] = '0;
        sample_count = '0;
      end
      default: ;
    endcase
    r.total_samples = sample_count;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void push_command(logic [1:0] kind, logic [31:0] smp,
                                       logic [7:0] sel, bit hold);
    queued_cmd_t q;
    q.cmd.kind = kind;
    q.cmd.sample = smp;
    q.cmd.bin_select = sel;
    q.hold = hold;
    commands_waiting.push_back(q);
  endfunction

  // mostly in-range samples and reads of live bins, some edges and noise
  function automatic void push_random_command();
    logic [1:0]  kind;
    logic [31:0] smp;
    logic [7:0]  sel;
    logic [63:0] span;
    logic [63:0] pick;
    int          r;
    smp = $urandom;
    sel = 8'($urandom);
    r = $urandom_range(0, 199);
    if (r < 130) kind = KIND_SAMPLE;
    else if (r < 186) kind = KIND_READ;
    else if (r < 190) kind = KIND_CLEAR;
    else kind = KIND_UNUSED;
    if (kind == KIND_SAMPLE) begin
      r = $urandom_range(0, 99);
      if (r < 65 && lo_edge <= hi_edge) begin
        span = longint'(hi_edge) - longint'(lo_edge) + 1;
        pick = {$urandom, $urandom} % span;
        smp = lo_edge + pick[31:0];
      end else if (r < 85) begin
        case ($urandom_range(0, 5))
          0: smp = lo_edge;
          1: smp = hi_edge;
          2: smp = lo_edge - 1;
          3: smp = hi_edge + 1;
          4: smp = lo_edge + 1;
          default: smp = hi_edge - 1;
        endcase
      end
    end else if (kind == KIND_READ && $urandom_range(0, 4) != 0) begin
      sel = 8'($urandom_range(0, active_bins() - 1));
    end
    push_command(kind, smp, sel, $urandom_range(0, 99) == 0);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_RANGE_LOW:  lo_edge = val;
      REG_RANGE_HIGH: hi_edge = val;
      REG_BINS_USED:  bins_used = val[8:0];
      REG_INV_WIDTH:  bins_per_unit = val;
      default: ;
    endcase
  endtask

  task automatic read_reg_check(logic [1:0] idx, logic [31:0] want);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("register readback", want, got);
  endtask

  task automatic set_config(logic [31:0] lo, logic [31:0] hi, logic [8:0] n,
                            logic [31:0] inv);
    write_reg(REG_RANGE_LOW, lo);
    write_reg(REG_RANGE_HIGH, hi);
    write_reg(REG_BINS_USED, {23'd0, n});
    write_reg(REG_INV_WIDTH, inv);
    read_reg_check(REG_RANGE_LOW, lo);
    read_reg_check(REG_RANGE_HIGH, hi);
    read_reg_check(REG_BINS_USED, {23'd0, n});
    read_reg_check(REG_INV_WIDTH, inv);
  endtask

  // range and bin width that match each other, optionally a random scale
  task automatic random_config(bit wild_scale);
    int          n;
    longint      lo;
    longint      hi;
    longint      width;
    logic [63:0] inv;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 256);
    lo = longint'($signed($urandom)) >>> $urandom_range(0, 16);
    width = longint'($urandom) >> $urandom_range(0, 24);
    if (width == 0) width = 1;
    hi = lo + width;
    if (hi > 2147483647) hi = 2147483647;
    width = hi - lo;
    inv = (width == 0) ? 64'hFFFF_FFFF : (longint'(n) << 32) / width;
    if (inv > 64'hFFFF_FFFF) inv = 64'hFFFF_FFFF;
    if (wild_scale) inv = $urandom;
    set_config(lo[31:0], hi[31:0], n[8:0], inv[31:0]);
  endtask

  // hold until every item has gone out and every report has come back
  task automatic wait_quiet();
    while (commands_waiting.size() != 0 || start || reports_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // item driver
  always @(negedge clk) begin : driver
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (commands_waiting.size() == 0 ||
                   (commands_waiting[0].hold && reports_due.size() != 0)) begin
        start <= 1'b0;
      end else begin
        item <= commands_waiting[0].cmd;
        commands_waiting.pop_front();
        start <= 1'b1;
        gap_left = no_gaps ? 0 : pick_gap();
      end
    end
  end

  // accepted items feed the mirror, reports are checked in order
  always @(posedge clk) begin : monitor
    out_item_t want;
    taken = !rst && start && !busy;
    if (taken) reports_due.push_back(tally_command(item));
    if (!rst && done) begin
      if (reports_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result);
        errors++;
      end else begin
        want = reports_due.pop_front();
        check_field("in_range", want.in_range, result.in_range);
        check_field("bin_value", want.bin_value, result.bin_value);
        check_field("total_samples", want.total_samples, result.total_samples);
      end
    end
  end

  // stop a hung run
  always @(posedge clk) begin : watchdog
    if ((start && !busy) || done === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("histogram_binning_engine_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int p;
    foreach (bin_tally[i]) bin_tally[i] = '0;
    sample_count = '0;
    lo_edge = RANGE_LOW_RST;
    hi_edge = RANGE_HIGH_RST;
    bins_used = BINS_USED_RST;
    bins_per_unit = INV_WIDTH_RST;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // edges of the default unit range, reads, unused kind and clear
    push_command(KIND_SAMPLE, 32'h0000_0000, 8'h00, 1'b0);
    push_command(KIND_SAMPLE, 32'h0001_0000, 8'hFF, 1'b0);
    push_command(KIND_SAMPLE, 32'h0000_FFFF, 8'h00, 1'b0);
    push_command(KIND_SAMPLE, 32'h0001_0001, 8'h00, 1'b0);
    push_command(KIND_SAMPLE, 32'hFFFF_FFFF, 8'h00, 1'b0);
    push_command(KIND_SAMPLE, 32'h8000_0000, 8'h00, 1'b0);
    push_command(KIND_SAMPLE, 32'h7FFF_FFFF, 8'h00, 1'b0);
    push_command(KIND_SAMPLE, 32'h0000_8000, 8'h00, 1'b0);
    push_command(KIND_SAMPLE, 32'h0000_0100, 8'h00, 1'b0);
    push_command(KIND_SAMPLE, 32'h0000_00FF, 8'h00, 1'b0);
    push_command(KIND_READ, 32'h0000_0000, 8'h00, 1'b0);
    push_command(KIND_READ, 32'h0000_0000, 8'hFF, 1'b0);
    push_command(KIND_READ, 32'hFFFF_FFFF, 8'h80, 1'b0);
    push_command(KIND_READ, 32'h0000_0000, 8'h01, 1'b0);
    push_command(KIND_READ, 32'h0000_0000, 8'h02, 1'b0);
    push_command(KIND_UNUSED, 32'hAAAA_AAAA, 8'h55, 1'b0);
    push_command(KIND_READ, 32'h5555_5555, 8'hAA, 1'b0);
    push_command(KIND_CLEAR, 32'h0000_0000, 8'h00, 1'b0);
    push_command(KIND_READ, 32'h0000_0000, 8'h00, 1'b1);
    push_command(KIND_READ, 32'h0000_0000, 8'hFF, 1'b0);
    push_command(KIND_SAMPLE, 32'h0000_FFFF, 8'h00, 1'b0);
    push_command(KIND_READ, 32'h0000_0000, 8'hFF, 1'b0);
    push_command(KIND_UNUSED, 32'h5555_5555, 8'hAA, 1'b0);
    wait_quiet();

    for (p = 1; p <= PHASES; p++) begin
      case (p)
        1: set_config(32'h8000_0000, 32'h7FFF_FFFF, 9'd256, 32'd256);
        // inverted range: nothing lands in a bin
        2: set_config(32'h7FFF_FFFF, 32'h8000_0000, 9'd0, 32'hFFFF_FFFF);
        3: set_config(32'hFFFC_0000, 32'h0004_0000, 9'd511, 32'hFFFF_FFFF);
        // single-point range with a zero scale
        4: set_config(32'h0003_0000, 32'h0003_0000, 9'd1, 32'd0);
        5: set_config(32'h0000_0000, 32'h0010_0000, 9'd0, 32'h0001_0000);
        default: random_config(p == PHASES);
      endcase
      no_gaps = (p % 3 == 0);
      repeat (ITEMS_PER_PHASE) push_random_command();
      wait_quiet();
    end

    if (errors == 0) begin
      $display("histogram_binning_engine_unit: match");
    end else begin
      $display("histogram_binning_engine_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: histogram_binning_engine_unit.f
sv/hbe_pkg.sv
sv/hbe_ram.sv
sv/hbe_queue.sv
sv/hbe_front.sv
sv/hbe_back.sv
sv/histogram_binning_engine_unit.sv
dv/histogram_binning_engine_unit_test.sv
